[hdl/spi_nps_pkg.sv]
// spi_nps_pkg: shared types, opcodes and constants of the spi nor page program sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package spi_nps_pkg;

  // page size in bytes, a power of two between 16 and 4096
  localparam int unsigned PageBytes = 256;
  localparam int unsigned PageW     = $clog2(PageBytes);

  // most results one request can cause: a deselect or timeout then a chunk header
  localparam int unsigned MaxRes = 7;
  localparam int unsigned IdxW   = $clog2(MaxRes);
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned HdrLen = 6;

  localparam logic [15:0] PollReset = 16'h2000;

  localparam logic [7:0] OpWren    = 8'h06;
  localparam logic [7:0] OpProgram = 8'h02;
  localparam logic [7:0] OpStatus  = 8'h05;
  localparam logic [7:0] OpRead    = 8'h03;
  localparam logic [7:0] Dummy     = 8'hFF;

  typedef enum logic [1:0] {
    ModeStartWrite = 2'd0,
    ModeTick       = 2'd1,
    ModeStartRead  = 2'd2,
    ModeStatus     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhWriting = 2'd1,
    PhWaiting = 2'd2,
    PhReading = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ActShift    = 2'd0,
    ActDeselect = 2'd1,
    ActTimeout  = 2'd2
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  tx;
    logic        cap;
  } entry_t;

  // one element of the page program header, high address byte first
  function automatic entry_t hdr_entry(input logic [IdxW-1:0] k, input logic [23:0] addr);
    entry_t e;
    e = '{action: ActShift, tx: 8'h00, cap: 1'b0};
    case (k)
      3'd0:    e.tx = OpWren;
      3'd1:    e.action = ActDeselect;
      3'd2:    e.tx = OpProgram;
      3'd3:    e.tx = addr[23:16];
      3'd4:    e.tx = addr[15:8];
      3'd5:    e.tx = addr[7:0];
      default: e = '{action: ActShift, tx: 8'h00, cap: 1'b0};
    endcase
    return e;
  endfunction

endpackage

[hdl/spi_nps_seq.sv]
// spi_nps_seq: transaction state and the builder of one request's list of bus actions
// depends on spi_nps_pkg
`timescale 1ns / 1ps

module spi_nps_seq (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          take_i,
  input  logic [1:0]                                    mode_i,
  input  logic [23:0]                                   flash_address_i,
  input  logic [15:0]                                   byte_count_i,
  input  logic [7:0]                                    data_value_i,
  input  logic [15:0]                                   poll_limit_i,
  output spi_nps_pkg::entry_t [spi_nps_pkg::MaxRes-1:0] batch_o,
  output logic [spi_nps_pkg::CntW-1:0]                  batch_cnt_o
);

  spi_nps_pkg::phase_e phase_q, phase_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] left_q, left_d;
  logic [15:0] polls_q, polls_d;

  spi_nps_pkg::entry_t [spi_nps_pkg::MaxRes-1:0] ent;
  logic [spi_nps_pkg::CntW-1:0] n_v;
  logic        hdr;
  logic        hdr_base;
  logic [23:0] hdr_addr;
  logic [23:0] addr_inc;
  logic [15:0] left_dec;

  assign addr_inc = addr_q + 24'd1;
  assign left_dec = left_q - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= spi_nps_pkg::PhIdle;
      addr_q  <= '0;
      left_q  <= '0;
      polls_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      polls_q <= polls_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    left_d   = left_q;
    polls_d  = polls_q;
    hdr      = 1'b0;
    hdr_base = 1'b0;
    hdr_addr = addr_q;
    n_v      = '0;
    for (int i = 0; i < int'(spi_nps_pkg::MaxRes); i++) begin
      ent[i] = '{action: spi_nps_pkg::ActShift, tx: 8'h00, cap: 1'b0};
    end

    case (spi_nps_pkg::mode_e'(mode_i))
      spi_nps_pkg::ModeStartWrite: begin
        if (phase_q == spi_nps_pkg::PhIdle && byte_count_i != 16'd0) begin
          addr_d   = flash_address_i;
          left_d   = byte_count_i;
          hdr      = 1'b1;
          hdr_addr = flash_address_i;
          phase_d  = spi_nps_pkg::PhWriting;
        end
      end
      spi_nps_pkg::ModeStartRead: begin
        if (phase_q == spi_nps_pkg::PhIdle) begin
          addr_d = flash_address_i;
          left_d = byte_count_i;
          ent[0] = '{action: spi_nps_pkg::ActShift, tx: spi_nps_pkg::OpRead, cap: 1'b0};
          ent[1] = '{action: spi_nps_pkg::ActShift, tx: flash_address_i[23:16], cap: 1'b0};
          ent[2] = '{action: spi_nps_pkg::ActShift, tx: flash_address_i[15:8], cap: 1'b0};
          ent[3] = '{action: spi_nps_pkg::ActShift, tx: flash_address_i[7:0], cap: 1'b0};
          if (byte_count_i == 16'd0) begin
            ent[4] = '{action: spi_nps_pkg::ActDeselect, tx: 8'h00, cap: 1'b0};
            n_v    = spi_nps_pkg::CntW'(5);
          end else begin
            n_v     = spi_nps_pkg::CntW'(4);
            phase_d = spi_nps_pkg::PhReading;
          end
        end
      end
      spi_nps_pkg::ModeTick: begin
        if (phase_q == spi_nps_pkg::PhWriting) begin
          addr_d = addr_inc;
          left_d = left_dec;
          ent[0] = '{action: spi_nps_pkg::ActShift, tx: data_value_i, cap: 1'b0};
          n_v    = spi_nps_pkg::CntW'(1);
          // chunk closes at the end of the data or on a page boundary
          if (left_dec == 16'd0 || addr_inc[spi_nps_pkg::PageW-1:0] == '0) begin
            ent[1]  = '{action: spi_nps_pkg::ActDeselect, tx: 8'h00, cap: 1'b0};
            ent[2]  = '{action: spi_nps_pkg::ActShift, tx: spi_nps_pkg::OpStatus, cap: 1'b0};
            ent[3]  = '{action: spi_nps_pkg::ActShift, tx: spi_nps_pkg::Dummy, cap: 1'b1};
            n_v     = spi_nps_pkg::CntW'(4);
            phase_d = spi_nps_pkg::PhWaiting;
            polls_d = poll_limit_i;
          end
        end else if (phase_q == spi_nps_pkg::PhReading) begin
          addr_d = addr_inc;
          left_d = left_dec;
          ent[0] = '{action: spi_nps_pkg::ActShift, tx: spi_nps_pkg::Dummy, cap: 1'b1};
          n_v    = spi_nps_pkg::CntW'(1);
          if (left_dec == 16'd0) begin
            ent[1]  = '{action: spi_nps_pkg::ActDeselect, tx: 8'h00, cap: 1'b0};
            n_v     = spi_nps_pkg::CntW'(2);
            phase_d = spi_nps_pkg::PhIdle;
          end
        end
      end
      spi_nps_pkg::ModeStatus: begin
        if (phase_q == spi_nps_pkg::PhWaiting) begin
          n_v = spi_nps_pkg::CntW'(1);
          if (polls_q == 16'd0) begin
            ent[0] = '{action: spi_nps_pkg::ActTimeout, tx: 8'h00, cap: 1'b0};
          end else begin
            polls_d = polls_q - 16'd1;
            if (data_value_i[0]) begin
              ent[0] = '{action: spi_nps_pkg::ActShift, tx: spi_nps_pkg::Dummy, cap: 1'b1};
            end else begin
              ent[0] = '{action: spi_nps_pkg::ActDeselect, tx: 8'h00, cap: 1'b0};
            end
          end
          // wait over: next chunk if bytes remain, otherwise back to idle
          if (polls_q == 16'd0 || !data_value_i[0]) begin
            if (left_q != 16'd0) begin
              hdr      = 1'b1;
              hdr_base = 1'b1;
              phase_d  = spi_nps_pkg::PhWriting;
            end else begin
              phase_d = spi_nps_pkg::PhIdle;
            end
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (hdr) begin
      for (int k = 0; k < int'(spi_nps_pkg::HdrLen); k++) begin
        ent[spi_nps_pkg::IdxW'(k) + spi_nps_pkg::IdxW'(hdr_base)] =
          spi_nps_pkg::hdr_entry(spi_nps_pkg::IdxW'(k), hdr_addr);
      end
      n_v = spi_nps_pkg::CntW'(spi_nps_pkg::HdrLen) + spi_nps_pkg::CntW'(hdr_base);
    end
  end

  assign batch_o     = ent;
  assign batch_cnt_o = n_v;

endmodule

[hdl/spi_nor_page_program_sequencer_unit.sv]
// spi_nor_page_program_sequencer_unit: top level, request intake, result buffering and output
// depends on spi_nps_pkg and spi_nps_seq
// the results of an accepted request are registered in the pending batch, then in the output
// buffer once that is free, and the output shows them from that buffer
// throughput: one result per cycle while out_stall_i is low; a request gives up to seven results,
// and a request is taken whenever the one-deep pending batch is free or moves on to the output
// in that cycle; requests that cause no result leave the pending batch empty
// reset: asynchronous, active low; clears the phase and counters, empties the buffers, poll_limit to 8192
`timescale 1ns / 1ps

module spi_nor_page_program_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [23:0] flash_address_i,
  input  logic [15:0] byte_count_i,
  input  logic [7:0]  data_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  tx_byte_o,
  output logic        capture_o,
  output logic        last_o
);

  logic [15:0] poll_limit_q;
  logic        take;

  spi_nps_pkg::entry_t [spi_nps_pkg::MaxRes-1:0] batch;
  logic [spi_nps_pkg::CntW-1:0] batch_cnt;

  spi_nps_pkg::entry_t [spi_nps_pkg::MaxRes-1:0] pend_q;
  logic [spi_nps_pkg::CntW-1:0] pend_cnt_q;
  logic                          pend_valid_q;

  spi_nps_pkg::entry_t [spi_nps_pkg::MaxRes-1:0] cur_q;
  logic [spi_nps_pkg::CntW-1:0] cur_cnt_q;
  logic [spi_nps_pkg::IdxW-1:0] cur_idx_q;
  logic                          cur_valid_q;

  spi_nps_pkg::entry_t cur_ent;
  logic                pop;
  logic                cur_last;
  logic                cur_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= spi_nps_pkg::PollReset;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_wdata_i;
    end
  end

  // the pending batch can take a new request in the cycle it moves to the output
  assign in_stall_o = pend_valid_q && !cur_free;
  assign take       = in_valid_i && !in_stall_o;

  spi_nps_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .mode_i         (mode_i),
    .flash_address_i(flash_address_i),
    .byte_count_i   (byte_count_i),
    .data_value_i   (data_value_i),
    .poll_limit_i   (poll_limit_q),
    .batch_o        (batch),
    .batch_cnt_o    (batch_cnt)
  );

  assign cur_ent  = cur_q[cur_idx_q];
  assign cur_last = (spi_nps_pkg::CntW'(cur_idx_q) + spi_nps_pkg::CntW'(1)) == cur_cnt_q;
  assign pop      = cur_valid_q && !out_stall_i;
  assign cur_free = !cur_valid_q || (pop && cur_last);

  // pending batch: only filled when the request causes at least one result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (take && batch_cnt != '0) begin
      pend_valid_q <= 1'b1;
    end else if (pend_valid_q && cur_free) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_q     <= batch;
      pend_cnt_q <= batch_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_idx_q   <= '0;
    end else if (cur_free) begin
      cur_valid_q <= pend_valid_q;
      cur_idx_q   <= '0;
    end else if (pop) begin
      cur_idx_q <= cur_idx_q + spi_nps_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_free && pend_valid_q) begin
      cur_q     <= pend_q;
      cur_cnt_q <= pend_cnt_q;
    end
  end

  assign out_valid_o = cur_valid_q;
  assign action_o    = cur_ent.action;
  assign tx_byte_o   = cur_ent.tx;
  assign capture_o   = cur_ent.cap;
  assign last_o      = cur_last;

endmodule

[hdl/spi_nps_checker.sv]
// spi_nps_assert: port-level checks on the result channel of the sequencer
// depends on spi_nps_pkg for action codes; bound to spi_nor_page_program_sequencer_unit
`timescale 1ns / 1ps

module spi_nps_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] action_o,
  input logic [7:0] tx_byte_o,
  input logic       capture_o,
  input logic       last_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) && $stable(tx_byte_o)
      && $stable(capture_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= spi_nps_pkg::ActTimeout)
    else $error("undefined action code");

  // deselect and timeout carry no byte and capture nothing
  a_quiet_deselect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != spi_nps_pkg::ActShift |-> tx_byte_o == 8'h00 && !capture_o)
    else $error("deselect with byte or capture");

  // only dummy transfers capture
  a_capture_dummy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capture_o |-> action_o == spi_nps_pkg::ActShift
      && tx_byte_o == spi_nps_pkg::Dummy)
    else $error("capture on a non-dummy byte");

endmodule

bind spi_nor_page_program_sequencer_unit spi_nps_assert u_spi_nps_assert (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .action_o   (action_o),
  .tx_byte_o  (tx_byte_o),
  .capture_o  (capture_o),
  .last_o     (last_o)
);

[dv/spi_nps_checker.sv]
// spi_nps_checker: watches the request, result and configuration ports of the sequencer,
// predicts every bus action and compares it with what comes out
// depends on spi_nps_pkg for modes, phases, actions, opcodes and the page size
`timescale 1ns / 1ps

module spi_nps_checker
  import spi_nps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [23:0] flash_address_i,
  input  logic [15:0] byte_count_i,
  input  logic [7:0]  data_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        capture_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned requests_o,
  output int unsigned results_o,
  output int unsigned timeouts_o
);

  typedef struct packed {
    action_e    action;
    logic [7:0] tx;
    logic       cap;
    logic       last;
  } bus_op_t;

  phase_e      seq_phase;
  logic [23:0] cur_addr;
  logic [15:0] left_bytes;
  logic [15:0] polls_left;
  logic [15:0] poll_limit;

  bus_op_t     bus_ops_q[$];
  bus_op_t     batch_q[$];
  bus_op_t     want_op;
  bus_op_t     got_op;

  int unsigned mismatches = 0;
  int unsigned n_requests = 0;
  int unsigned n_results  = 0;
  int unsigned n_timeouts = 0;

  function automatic void emit(action_e act, logic [7:0] byte_v, logic cap);
    bus_op_t op;
    op = '{action: act, tx: byte_v, cap: cap, last: 1'b0};
    batch_q.push_back(op);
  endfunction

  function automatic void emit_addr();
    emit(ActShift, cur_addr[23:16], 1'b0);
    emit(ActShift, cur_addr[15:8], 1'b0);
    emit(ActShift, cur_addr[7:0], 1'b0);
  endfunction

  function automatic void open_page_program();
    emit(ActShift, OpWren, 1'b0);
    emit(ActDeselect, 8'h00, 1'b0);
    emit(ActShift, OpProgram, 1'b0);
    emit_addr();
    seq_phase = PhWriting;
  endfunction

  // a wait ends by going on with the next chunk, or back to idle
  function automatic void finish_wait();
    if (left_bytes != 16'd0) begin
      open_page_program();
    end else begin
      seq_phase = PhIdle;
    end
  endfunction

  function automatic void predict_bus_ops(mode_e m, logic [23:0] a, logic [15:0] c,
                                          logic [7:0] d);
    bus_op_t op;
    batch_q.delete();
    case (m)
      ModeStartWrite: begin
        if (seq_phase == PhIdle && c != 16'd0) begin
          cur_addr   = a;
          left_bytes = c;
          open_page_program();
        end
      end
      ModeStartRead: begin
        if (seq_phase == PhIdle) begin
          cur_addr   = a;
          left_bytes = c;
          emit(ActShift, OpRead, 1'b0);
          emit_addr();
          if (c == 16'd0) begin
            emit(ActDeselect, 8'h00, 1'b0);
          end else begin
            seq_phase = PhReading;
          end
        end
      end
      ModeTick: begin
        if (seq_phase == PhWriting) begin
          emit(ActShift, d, 1'b0);
          cur_addr   = cur_addr + 24'd1;
          left_bytes = left_bytes - 16'd1;
          // chunk closes at the end of the data or on a page boundary
          if (left_bytes == 16'd0 || cur_addr[PageW-1:0] == '0) begin
            emit(ActDeselect, 8'h00, 1'b0);
            emit(ActShift, OpStatus, 1'b0);
            emit(ActShift, Dummy, 1'b1);
            seq_phase  = PhWaiting;
            polls_left = poll_limit;
          end
        end else if (seq_phase == PhReading) begin
          emit(ActShift, Dummy, 1'b1);
          cur_addr   = cur_addr + 24'd1;
          left_bytes = left_bytes - 16'd1;
          if (left_bytes == 16'd0) begin
            emit(ActDeselect, 8'h00, 1'b0);
            seq_phase = PhIdle;
          end
        end
      end
      default: begin
        if (seq_phase == PhWaiting) begin
          if (polls_left == 16'd0) begin
            emit(ActTimeout, 8'h00, 1'b0);
            finish_wait();
          end else begin
            polls_left = polls_left - 16'd1;
            if (d[0]) begin
              emit(ActShift, Dummy, 1'b1);
            end else begin
              emit(ActDeselect, 8'h00, 1'b0);
              finish_wait();
            end
          end
        end
      end
    endcase
    if (batch_q.size() != 0) begin
      op      = batch_q.pop_back();
      op.last = 1'b1;
      batch_q.push_back(op);
    end
    while (batch_q.size() != 0) bus_ops_q.push_back(batch_q.pop_front());
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase  = PhIdle;
      cur_addr   = '0;
      left_bytes = '0;
      polls_left = '0;
      poll_limit = PollReset;
      bus_ops_q.delete();
      fail_count_o <= mismatches;
      pending_o    <= 0;
      requests_o   <= n_requests;
      results_o    <= n_results;
      timeouts_o   <= n_timeouts;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_op = '{action: action_e'(action_i), tx: tx_byte_i, cap: capture_i, last: last_i};
        n_results++;
        if (bus_ops_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] unexpected result: action %0d tx %02h capture %0b last %0b",
                     $realtime, got_op.action, got_op.tx, got_op.cap, got_op.last);
          end
          mismatches++;
        end else begin
          want_op = bus_ops_q.pop_front();
          if (want_op.action == ActTimeout) n_timeouts++;
          if (got_op.action != want_op.action || got_op.tx != want_op.tx ||
              got_op.cap != want_op.cap || got_op.last != want_op.last) begin
            if (mismatches < 10) begin
              $display("[%0t] result %0d: expected action %0d tx %02h capture %0b last %0b",
                       $realtime, n_results, want_op.action, want_op.tx, want_op.cap,
                       want_op.last);
              $display("[%0t] result %0d:      got action %0d tx %02h capture %0b last %0b",
                       $realtime, n_results, got_op.action, got_op.tx, got_op.cap,
                       got_op.last);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) poll_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        n_requests++;
        predict_bus_ops(mode_e'(mode_i), flash_address_i, byte_count_i, data_value_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= bus_ops_q.size();
      requests_o   <= n_requests;
      results_o    <= n_results;
      timeouts_o   <= n_timeouts;
    end
  end

endmodule

[dv/tb_top.sv]
// tb_top: clock, reset and request stimulus for the spi nor page program sequencer,
// with a checker beside the block that gives the failure count for the verdict
// depends on spi_nps_pkg, spi_nor_page_program_sequencer_unit and spi_nps_checker
`timescale 1ns / 1ps

module tb_top;
  import spi_nps_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 16;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  mode_e       in_mode;
  logic [23:0] in_addr;
  logic [15:0] in_count;
  logic [7:0]  in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_action;
  logic [7:0]  out_tx;
  logic        out_capture;
  logic        out_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_timeouts;

  int unsigned cycle_cnt   = 0;
  int unsigned burst_left  = 0;
  int unsigned useful_cnt  = 0;
  int unsigned stall_style = 0;
  int unsigned style_left  = 0;

  spi_nor_page_program_sequencer_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (in_mode),
    .flash_address_i(in_addr),
    .byte_count_i   (in_count),
    .data_value_i   (in_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .action_o       (out_action),
    .tx_byte_o      (out_tx),
    .capture_o      (out_capture),
    .last_o         (out_last)
  );

  spi_nps_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (in_mode),
    .flash_address_i(in_addr),
    .byte_count_i   (in_count),
    .data_value_i   (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .action_i       (out_action),
    .tx_byte_i      (out_tx),
    .capture_i      (out_capture),
    .last_i         (out_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .requests_o     (n_requests),
    .results_o      (n_results),
    .timeouts_o     (n_timeouts)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("run stopped after %0d cycles with %0d results outstanding", cycle_cnt, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: free running, random, never stalled, stalled at random, mostly stalled or toggling, each for a while
  always @(posedge clk) begin
    if (style_left == 0) begin
      style_left  = $urandom_range(20, 200);
      stall_style = $urandom_range(0, 3);
    end else begin
      style_left--;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 1);
      2:       out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic send_req(input mode_e m, input logic [23:0] a, input logic [15:0] c,
                          input logic [7:0] d, input bit useful);
    in_valid <= 1'b1;
    in_mode  <= m;
    in_addr  <= a;
    in_count <= c;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (useful) useful_cnt++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  // a request the sequencer must ignore in the phase it is in
  task automatic send_stray(input phase_e ph);
    bit pick;
    mode_e start_m;
    pick    = ($urandom_range(0, 1) == 1);
    start_m = pick ? ModeStartWrite : ModeStartRead;
    case (ph)
      PhIdle: begin
        if (pick) send_req(ModeTick, 24'($urandom), 16'($urandom), 8'($urandom), 1'b0);
        else send_req(ModeStatus, 24'($urandom), 16'($urandom), 8'($urandom), 1'b0);
      end
      PhWaiting: begin
        if ($urandom_range(0, 1) == 1) begin
          send_req(ModeTick, 24'($urandom), 16'($urandom), 8'($urandom), 1'b0);
        end else begin
          send_req(start_m, 24'($urandom), 16'($urandom), 8'($urandom), 1'b0);
        end
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          send_req(ModeStatus, 24'($urandom), 16'($urandom), 8'($urandom), 1'b0);
        end else begin
          send_req(start_m, 24'($urandom), 16'($urandom), 8'($urandom), 1'b0);
        end
      end
    endcase
  endtask

  task automatic maybe_stray(input phase_e ph);
    if ($urandom_range(0, 99) < 15) send_stray(ph);
  endtask

  // well-formed write: data bytes, and after each chunk some busy polls then a ready
  // status; polls that follow a timeout land outside the wait and are ignored
  task automatic write_burst(input logic [23:0] start_addr, input logic [15:0] len);
    logic [23:0] a;
    logic [15:0] left;
    a    = start_addr;
    left = len;
    send_req(ModeStartWrite, start_addr, len, 8'($urandom), len != 16'd0);
    while (left != 16'd0) begin
      maybe_stray(PhWriting);
      send_req(ModeTick, 24'($urandom), 16'($urandom), 8'($urandom), 1'b1);
      a    = a + 24'd1;
      left = left - 16'd1;
      if (left == 16'd0 || a[PageW-1:0] == '0) begin
        maybe_stray(PhWaiting);
        repeat ($urandom_range(0, 3)) begin
          send_req(ModeStatus, 24'($urandom), 16'($urandom), 8'($urandom) | 8'h01, 1'b1);
        end
        send_req(ModeStatus, 24'($urandom), 16'($urandom), 8'($urandom) & 8'hFE, 1'b1);
      end
    end
    maybe_stray(PhIdle);
  endtask

  task automatic read_burst(input logic [23:0] a, input logic [15:0] len);
    send_req(ModeStartRead, a, len, 8'($urandom), 1'b1);
    repeat (len) begin
      maybe_stray(PhReading);
      send_req(ModeTick, 24'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    end
    maybe_stray(PhIdle);
  endtask

  // random, near the end of a page, or near the top of the address space
  function automatic logic [23:0] pick_address();
    logic [23:0] a;
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      a = 24'($urandom);
    end else if (k < 8) begin
      a = (24'($urandom) | 24'(PageBytes - 1)) - 24'($urandom_range(0, 10));
    end else begin
      a = 24'hFFFFFF - 24'($urandom_range(0, 12));
    end
    return a;
  endfunction

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned k;
    logic [15:0] len;
    stop_at = useful_cnt + n;
    while (useful_cnt < stop_at) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        if (k < 4) len = 16'($urandom_range(1, 10));
        else if (k < 5) len = 16'($urandom_range(11, 40));
        else len = 16'd0;
        write_burst(pick_address(), len);
      end else begin
        len = (k == 9) ? 16'd0 : 16'($urandom_range(1, 12));
        read_burst(pick_address(), len);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_poll_limit(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_mode   = ModeStartWrite;
    in_addr   = '0;
    in_count  = '0;
    in_data   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle: stray tick, stray status and an empty write give nothing
    send_req(ModeTick, 24'h000000, 16'h0000, 8'h00, 1'b0);
    send_req(ModeStatus, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0);
    send_req(ModeStartWrite, 24'hFFFFFF, 16'h0000, 8'hFF, 1'b0);
    // empty read gives opcode, address and deselect straight away
    send_req(ModeStartRead, 24'hABCDEF, 16'h0000, 8'h00, 1'b0);
    // write over the top of the address space, crossing a page boundary
    send_req(ModeStartWrite, 24'hFFFFFE, 16'd3, 8'h00, 1'b0);
    send_req(ModeStatus, 24'h000000, 16'h0000, 8'h00, 1'b0);
    send_req(ModeStartRead, 24'h123456, 16'hFFFF, 8'h00, 1'b0);
    send_req(ModeTick, 24'h000000, 16'h0000, 8'h00, 1'b0);
    send_req(ModeTick, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0);
    send_req(ModeTick, 24'h000000, 16'h0000, 8'h5A, 1'b0);
    send_req(ModeStartWrite, 24'h000100, 16'hFFFF, 8'h00, 1'b0);
    send_req(ModeStatus, 24'h000000, 16'h0000, 8'hFF, 1'b0);
    send_req(ModeStatus, 24'hFFFFFF, 16'hFFFF, 8'hFE, 1'b0);
    send_req(ModeTick, 24'h000000, 16'h0000, 8'hA5, 1'b0);
    send_req(ModeStatus, 24'h000000, 16'h0000, 8'h00, 1'b0);
    // read wrapping past the top address
    send_req(ModeStartRead, 24'hFFFFFF, 16'd2, 8'h00, 1'b0);
    send_req(ModeStatus, 24'h000000, 16'h0000, 8'h01, 1'b0);
    send_req(ModeTick, 24'h000000, 16'h0000, 8'h00, 1'b0);
    send_req(ModeTick, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       set_poll_limit(16'd1);
        2:       set_poll_limit(16'hFFFF);
        3:       set_poll_limit(16'($urandom_range(2, 4)));
        4:       set_poll_limit(16'd2);
        default: ;
      endcase
      random_traffic(54);
    end

    wait_drained();
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("%0d requests gave %0d bus actions, %0d of them poll timeouts", n_requests,
             n_results, n_timeouts);
    $display("poll limits: reset value, 1, 65535, a small random one and 2");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/spi_nps_pkg.sv
hdl/spi_nps_seq.sv
hdl/spi_nor_page_program_sequencer_unit.sv
hdl/spi_nps_checker.sv
dv/spi_nps_checker.sv
dv/tb_top.sv
